// ===== rtl/core/token_bucket_rate_limiter_assert.svh =====
// ----------------------------------------------------------------------------
// Token bucket rate limiter assertion macros
// Shorthand for clocked checks on clk, switched off while rst is high.
// ----------------------------------------------------------------------------
`ifndef TOKEN_BUCKET_RATE_LIMITER_ASSERT_SVH
`define TOKEN_BUCKET_RATE_LIMITER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TBRL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TBRL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tbrl_pkg.sv =====
// ----------------------------------------------------------------------------
// Token bucket rate limiter package
// Shared widths, payload and control types, codes and a helper function.
// ----------------------------------------------------------------------------
package tbrl_pkg;

  localparam int NUM_BUCKETS = 64;
  localparam int BUCKET_AW   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  // Wide enough to hold any bucket count up to 4096 for the range check.
  localparam int IDX_CMP_W   = 13;

  localparam int OP_W       = 2;
  localparam int IDX_W      = 6;
  localparam int TIME_W     = 48;
  localparam int CAP_W      = 24;
  localparam int RATE_W     = 16;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  localparam int MS_PER_SECOND = 1000;

  // Elapsed time saturates here; beyond it any non-zero rate fills the bucket.
  localparam int ELAPSED_W = 34;
  localparam int SCALED_W  = ELAPSED_W + RATE_W;
  // A scaled value at or above this gives a refill of at least 2^CAP_W tokens.
  localparam longint unsigned SCALED_LIMIT = 64'(MS_PER_SECOND) << CAP_W;

  // Division by 1000 is a shift by three followed by a reciprocal multiply
  // for 125, exact for every dividend below 2^31.
  localparam int DIV_SHIFT   = 3;
  localparam int QUOT_IN_W   = ELAPSED_W - DIV_SHIFT;
  localparam int RECIP_W     = 29;
  localparam logic [RECIP_W-1:0] RECIP_125 = 29'h10624DD3;
  localparam int RECIP_SHIFT = 35;
  localparam int RECIP_PROD_W = QUOT_IN_W + RECIP_W;
  localparam int ADD_W       = CAP_W + 1;
  localparam int SUM_W       = CAP_W + 2;

  localparam logic [CAP_W-1:0]  CAPACITY_RESET = 24'd100;
  localparam logic [RATE_W-1:0] REFILL_RESET   = 16'd10;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REFILL   = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_CONSUME = 2'd0,
    OP_PEEK    = 2'd1,
    OP_RESET   = 2'd2
  } opcode_t;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [IDX_W-1:0]  bucket_index;
    logic [TIME_W-1:0] now_ms;
    logic [CAP_W-1:0]  tokens_wanted;
  } req_t;

  typedef struct packed {
    logic              granted;
    logic [CAP_W-1:0]  tokens_left;
    logic [CNT_W-1:0]  request_total;
    logic [CNT_W-1:0]  grant_total;
    logic [CNT_W-1:0]  reject_total;
  } rsp_t;

  typedef struct packed {
    logic [CAP_W-1:0]  level;
    logic [TIME_W-1:0] stamp;
    logic [CNT_W-1:0]  seen;
    logic [CNT_W-1:0]  granted;
    logic [CNT_W-1:0]  refused;
  } bucket_entry_t;

  localparam int ENTRY_W = $bits(bucket_entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_DIVIDE,
    ST_COMMIT
  } tbrl_state_t;

  typedef struct packed {
    logic accept;
    logic scale;
    logic divide;
    logic commit;
  } tbrl_cmd_t;

  typedef struct packed {
    logic out_room;
  } tbrl_status_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

endpackage

// ===== rtl/core/token_bucket_rate_limiter.sv =====
// ----------------------------------------------------------------------------
// Token bucket rate limiter
// Per-bucket token policing with saturating request, grant and reject counts.
// ----------------------------------------------------------------------------
// Each item passes through the accepting cycle, whose edge issues the bucket
// memory read, then the multiply of elapsed time by the refill rate, then the
// reciprocal multiply that divides by 1000, and last the update of the bucket
// and the load of the result, which is presented after the commit edge. The
// next item is taken in the cycle after the commit, so the block takes no new
// item until the last one is committed; a result left waiting under stall
// holds the commit until the output register frees. Configuration writes are
// always ready; the registers are read in the scale and commit steps, so a
// write while an item is in progress can change that item. Live flags sit in
// flip-flops cleared by reset, so there is no memory clearing pass.
`include "token_bucket_rate_limiter_assert.svh"

module token_bucket_rate_limiter (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  output logic                                 req_stall,
  input  tbrl_pkg::req_t                       req,
  output logic                                 rsp_valid,
  input  logic                                 rsp_stall,
  output tbrl_pkg::rsp_t                       rsp,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tbrl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tbrl_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import tbrl_pkg::*;

  tbrl_cmd_t    cmd;
  tbrl_status_t status;

  assign cfg_ready = 1'b1;

  tbrl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tbrl_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .req       (req),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  `TBRL_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall,
    "request taken while the previous one is still in progress")
  `TBRL_ASSERT_SAME(a_commit_has_room, cmd.commit, !rsp_valid || !rsp_stall,
    "commit would overwrite a result still waiting")
  `TBRL_ASSERT_SAME(a_grant_counted, rsp_valid && rsp.granted,
    rsp.request_total != '0 && rsp.grant_total != '0,
    "granted result without a counted request and grant")

endmodule

// ===== rtl/core/tbrl_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module tbrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/tbrl_ctrl.sv =====
// ----------------------------------------------------------------------------
// Token bucket rate limiter controller
// Steps one item through fetch, scaling, division and commit.
// ----------------------------------------------------------------------------
module tbrl_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  tbrl_pkg::tbrl_status_t status,
  output tbrl_pkg::tbrl_cmd_t   cmd
);
  import tbrl_pkg::*;

  tbrl_state_t state;
  tbrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE:  state_next = ST_DIVIDE;
      ST_DIVIDE: state_next = ST_COMMIT;
      ST_COMMIT: begin
        // Hold until the result register can take the new item.
        if (status.out_room) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall  = 1'b1;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        req_stall  = 1'b0;
        cmd.accept = req_valid;
      end
      ST_SCALE:  cmd.scale  = 1'b1;
      ST_DIVIDE: cmd.divide = 1'b1;
      ST_COMMIT: cmd.commit = status.out_room;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/core/tbrl_datapath.sv =====
// ----------------------------------------------------------------------------
// Token bucket rate limiter datapath
// Bucket memory, live bits, refill arithmetic, counters and result register.
// ----------------------------------------------------------------------------
module tbrl_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tbrl_pkg::tbrl_cmd_t                  cmd,
  output tbrl_pkg::tbrl_status_t               status,
  input  tbrl_pkg::req_t                       req,
  input  logic                                 cfg_valid,
  input  logic [tbrl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tbrl_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 rsp_stall,
  output logic                                 rsp_valid,
  output tbrl_pkg::rsp_t                       rsp
);
  import tbrl_pkg::*;

  // Configuration registers.
  logic [CAP_W-1:0]  capacity;
  logic [RATE_W-1:0] rate_cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
      rate_cfg <= REFILL_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CAPACITY: capacity <= cfg_data[CAP_W-1:0];
        REG_REFILL:   rate_cfg <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured request.
  logic [OP_W-1:0]   op_r;
  logic [IDX_W-1:0]  idx_r;
  logic [TIME_W-1:0] now_r;
  logic [CAP_W-1:0]  want_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= req.opcode;
      idx_r  <= req.bucket_index;
      now_r  <= req.now_ms;
      want_r <= req.tokens_wanted;
    end
  end

  logic [BUCKET_AW-1:0] addr_r;
  logic                 in_range;
  assign addr_r   = BUCKET_AW'(idx_r);
  assign in_range = IDX_CMP_W'(idx_r) < IDX_CMP_W'(NUM_BUCKETS);

  // Bucket memory; the entry is read as the item is accepted.
  logic [ENTRY_W-1:0] rd_word;
  logic [ENTRY_W-1:0] wr_word;
  logic               wr_en;
  bucket_entry_t      rd_entry;
  bucket_entry_t      wr_entry;

  assign rd_entry = rd_word;
  assign wr_word  = wr_entry;

  tbrl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_BUCKETS)
  ) u_bucket_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (addr_r),
    .wr_data (wr_word),
    .rd_en   (cmd.accept),
    .rd_addr (BUCKET_AW'(req.bucket_index)),
    .rd_data (rd_word)
  );

  // Live flags, one per bucket.
  logic [NUM_BUCKETS-1:0] live;

  // Scale stage: elapsed time times refill rate.
  logic                  hit;
  logic [TIME_W-1:0]     stamp_eff;
  logic [TIME_W-1:0]     elapsed;
  logic [ELAPSED_W-1:0]  elapsed_sat;
  logic [SCALED_W-1:0]   scaled_next;
  logic [SCALED_W-1:0]   scaled;
  logic                  hit_q;

  assign hit         = in_range && live[addr_r];
  // A bucket that is not live starts with its stamp at now, so no refill.
  assign stamp_eff   = hit ? rd_entry.stamp : now_r;
  assign elapsed     = (now_r > stamp_eff) ? (now_r - stamp_eff) : '0;
  assign elapsed_sat = (|elapsed[TIME_W-1:ELAPSED_W]) ? '1 : elapsed[ELAPSED_W-1:0];
  assign scaled_next = SCALED_W'(elapsed_sat) * SCALED_W'(rate_cfg);

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      scaled <= scaled_next;
      hit_q  <= hit;
    end
  end

  // Divide stage: floor(scaled / 1000), clamped to 2^CAP_W.
  logic [QUOT_IN_W-1:0]    quot_in;
  logic [RECIP_PROD_W-1:0] recip_next;
  logic [RECIP_PROD_W-1:0] recip;
  logic                    over;

  assign quot_in    = scaled[ELAPSED_W-1:DIV_SHIFT];
  assign recip_next = RECIP_PROD_W'(quot_in) * RECIP_PROD_W'(RECIP_125);

  always_ff @(posedge clk) begin
    if (cmd.divide) begin
      recip <= recip_next;
      over  <= scaled >= SCALED_W'(SCALED_LIMIT);
    end
  end

  // Commit stage.
  logic [ADD_W-1:0]  add;
  logic              refill;
  logic [CAP_W-1:0]  base_level;
  logic [SUM_W-1:0]  sum;
  logic [CAP_W-1:0]  level_ref;
  logic              grant;
  logic [CAP_W-1:0]  level_fin;
  logic [CNT_W-1:0]  seen_new;
  logic [CNT_W-1:0]  granted_new;
  logic [CNT_W-1:0]  refused_new;
  logic              is_consume;
  logic              is_reset;
  rsp_t              rsp_next;

  assign add = over ? (ADD_W'(1) << CAP_W)
                    : recip[RECIP_SHIFT +: ADD_W];
  assign refill     = add != '0;
  assign base_level = hit_q ? rd_entry.level : capacity;
  assign sum        = SUM_W'(base_level) + SUM_W'(add);
  assign level_ref  = !refill ? base_level
                    : (sum > SUM_W'(capacity)) ? capacity : sum[CAP_W-1:0];
  assign grant      = level_ref >= want_r;
  assign level_fin  = grant ? (level_ref - want_r) : level_ref;

  assign seen_new    = sat_inc(hit_q ? rd_entry.seen : '0);
  assign granted_new = (hit_q ? rd_entry.granted : '0) + CNT_W'(0);
  assign refused_new = (hit_q ? rd_entry.refused : '0) + CNT_W'(0);

  assign is_consume = in_range && (op_r == OP_CONSUME);
  assign is_reset   = in_range && (op_r == OP_RESET);

  always_comb begin
    wr_entry.level   = level_fin;
    wr_entry.stamp   = refill ? now_r : (hit_q ? rd_entry.stamp : now_r);
    wr_entry.seen    = seen_new;
    wr_entry.granted = grant ? sat_inc(granted_new) : granted_new;
    wr_entry.refused = grant ? refused_new : sat_inc(refused_new);
  end

  assign wr_en = cmd.commit && is_consume;

  always_comb begin
    rsp_next             = '0;
    rsp_next.tokens_left = capacity;
    priority if (is_consume) begin
      rsp_next.granted       = grant;
      rsp_next.tokens_left   = wr_entry.level;
      rsp_next.request_total = wr_entry.seen;
      rsp_next.grant_total   = wr_entry.granted;
      rsp_next.reject_total  = wr_entry.refused;
    end else if (!is_reset && hit_q) begin
      // Peek, or the unused opcode, of a live bucket reports it unchanged.
      rsp_next.tokens_left   = rd_entry.level;
      rsp_next.request_total = rd_entry.seen;
      rsp_next.grant_total   = rd_entry.granted;
      rsp_next.reject_total  = rd_entry.refused;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
    end else if (cmd.commit) begin
      if (is_consume) begin
        live[addr_r] <= 1'b1;
      end else if (is_reset) begin
        live[addr_r] <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp <= rsp_next;
    end
  end

  assign status.out_room = !rsp_valid || !rsp_stall;

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Token bucket rate limiter testbench
// Drives request items with random idling on both sides, predicts each result
// from a behavioural bucket model kept in the bench or takes it from the plan,
// and compares each result field by field. The configuration is changed between phases while idle.
// ----------------------------------------------------------------------------
module tb;
  import tbrl_pkg::*;

  // The opcode value left unused by the block; it must behave as a peek.
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int HOLD_CYCLES = 60;
  localparam int TAIL_CYCLES = 20;
  localparam longint RUN_LIMIT = 2000000;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] now;
    logic [CAP_W-1:0]  want;
    logic              typed;
    rsp_t              rsp;
  } step_t;

  localparam rsp_t UNTYPED = '0;
  localparam rsp_t ABSENT  = '{1'b0, 24'd100, 32'd0, 32'd0, 32'd0};
  localparam logic [TIME_W-1:0] T_MAX = '1;

  // Directed opening, run under the reset configuration (100 tokens, 10 per second).
  localparam step_t PLAN [21] = '{
    '{OP_PEEK,    6'd0,  48'd0,    24'd0,   1'b1, ABSENT},
    '{OP_CONSUME, 6'd0,  48'd1000, 24'd30,  1'b1, '{1'b1, 24'd70, 32'd1, 32'd1, 32'd0}},
    '{OP_CONSUME, 6'd0,  48'd1000, 24'd71,  1'b1, '{1'b0, 24'd70, 32'd2, 32'd1, 32'd1}},
    '{OP_CONSUME, 6'd0,  48'd1500, 24'd0,   1'b0, UNTYPED},
    '{OP_CONSUME, 6'd0,  48'd1400, 24'd0,   1'b0, UNTYPED},
    '{OP_CONSUME, 6'd0,  48'd1599, 24'd0,   1'b0, UNTYPED},
    '{OP_CONSUME, 6'd0,  48'd1600, 24'd1,   1'b0, UNTYPED},
    '{OP_PEEK,    6'd0,  48'd0,    '1,      1'b0, UNTYPED},
    '{OP_SPARE,   6'd0,  48'd0,    24'd0,   1'b0, UNTYPED},
    '{OP_RESET,   6'd0,  48'd0,    24'd0,   1'b1, ABSENT},
    '{OP_PEEK,    6'd0,  48'd2000, 24'd0,   1'b1, ABSENT},
    '{OP_RESET,   6'd5,  48'd0,    24'd0,   1'b1, ABSENT},
    '{OP_CONSUME, 6'd63, T_MAX,    '1,      1'b1, '{1'b0, 24'd100, 32'd1, 32'd0, 32'd1}},
    '{OP_CONSUME, 6'd63, 48'd0,    24'd0,   1'b1, '{1'b1, 24'd100, 32'd2, 32'd1, 32'd1}},
    '{OP_CONSUME, 6'd42, 48'h555555555555, 24'hAAAAAA, 1'b1,
      '{1'b0, 24'd100, 32'd1, 32'd0, 32'd1}},
    '{OP_CONSUME, 6'd21, 48'hAAAAAAAAAAAA, 24'h555555, 1'b1,
      '{1'b0, 24'd100, 32'd1, 32'd0, 32'd1}},
    '{OP_CONSUME, 6'd1,  48'd0,    24'd100, 1'b1, '{1'b1, 24'd0, 32'd1, 32'd1, 32'd0}},
    '{OP_CONSUME, 6'd1,  T_MAX,    24'd1,   1'b0, UNTYPED},
    '{OP_RESET,   6'd63, 48'd0,    24'd0,   1'b1, ABSENT},
    '{OP_PEEK,    6'd63, 48'd0,    24'd0,   1'b1, ABSENT},
    '{OP_CONSUME, 6'd63, 48'd5000, 24'd0,   1'b1, '{1'b1, 24'd100, 32'd1, 32'd1, 32'd0}}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  req_t req = '0;
  logic rsp_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic req_stall;
  logic rsp_valid;
  logic cfg_ready;
  rsp_t rsp;

  token_bucket_rate_limiter dut (.*);

  always #5 clk = ~clk;

  // Bench copy of the configuration and of every bucket.
  logic [CAP_W-1:0]  cap_reg  = CAPACITY_RESET;
  logic [RATE_W-1:0] rate_reg = REFILL_RESET;
  bit                live_flag  [NUM_BUCKETS];
  logic [CAP_W-1:0]  level_mem  [NUM_BUCKETS];
  logic [TIME_W-1:0] stamp_mem  [NUM_BUCKETS];
  logic [CNT_W-1:0]  seen_mem   [NUM_BUCKETS];
  logic [CNT_W-1:0]  grant_mem  [NUM_BUCKETS];
  logic [CNT_W-1:0]  refuse_mem [NUM_BUCKETS];

  rsp_t pending_rsp [$];
  int fail_count = 0;
  int result_count = 0;
  bit quiet = 1'b0;
  logic [TIME_W-1:0] sim_ms = 48'd2000;

  // Applies one item to the bucket copy and returns the result it should give.
  function automatic rsp_t police(req_t it);
    rsp_t r;
    int unsigned b;
    logic [63:0] elapsed;
    logic [63:0] gain;
    logic [63:0] sum;
    r = '0;
    r.tokens_left = cap_reg;
    b = 32'(it.bucket_index);
    if (b >= NUM_BUCKETS) return r;
    if (it.opcode == OP_RESET) begin
      live_flag[b] = 1'b0;
      return r;
    end
    if (it.opcode == OP_CONSUME) begin
      if (!live_flag[b]) begin
        live_flag[b]  = 1'b1;
        level_mem[b]  = cap_reg;
        stamp_mem[b]  = it.now_ms;
        seen_mem[b]   = '0;
        grant_mem[b]  = '0;
        refuse_mem[b] = '0;
      end
      if (it.now_ms > stamp_mem[b]) begin
        elapsed = 64'(it.now_ms - stamp_mem[b]);
        gain = (elapsed * 64'(rate_reg)) / 64'd1000;
        // The stamp only moves when at least one whole token is added.
        if (gain != 0) begin
          sum = 64'(level_mem[b]) + gain;
          if (sum > 64'(cap_reg)) sum = 64'(cap_reg);
          level_mem[b] = sum[CAP_W-1:0];
          stamp_mem[b] = it.now_ms;
        end
      end
      if (~&seen_mem[b]) seen_mem[b]++;
      if (level_mem[b] >= it.tokens_wanted) begin
        level_mem[b] -= it.tokens_wanted;
        r.granted = 1'b1;
        if (~&grant_mem[b]) grant_mem[b]++;
      end else begin
        if (~&refuse_mem[b]) refuse_mem[b]++;
      end
    end
    if (live_flag[b]) begin
      r.tokens_left   = level_mem[b];
      r.request_total = seen_mem[b];
      r.grant_total   = grant_mem[b];
      r.reject_total  = refuse_mem[b];
    end
    return r;
  endfunction

  // Mostly well-formed traffic on a few buckets with a rising clock, the rest noise.
  function automatic req_t pick_item();
    req_t it;
    int unsigned roll;
    int unsigned span;
    logic [63:0] wide;
    if ($urandom_range(0, 99) < 80) begin
      sim_ms += ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5000) : $urandom_range(0, 300);
      roll = $urandom_range(0, 99);
      if (roll < 80)      it.opcode = OP_CONSUME;
      else if (roll < 92) it.opcode = OP_PEEK;
      else                it.opcode = OP_RESET;
      it.bucket_index = IDX_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                           : $urandom_range(0, 7));
      it.now_ms = sim_ms;
      span = (cap_reg == 0) ? 1 : cap_reg / 3 + 1;
      it.tokens_wanted = CAP_W'($urandom_range(0, span));
    end else begin
      it.opcode = OP_W'($urandom_range(0, 3));
      it.bucket_index = IDX_W'($urandom_range(0, 63));
      wide = {$urandom, $urandom};
      // Half the noise goes slightly back in time rather than anywhere at all.
      it.now_ms = $urandom_range(0, 1) ? wide[TIME_W-1:0] : sim_ms - $urandom_range(0, 1000);
      it.tokens_wanted = CAP_W'($urandom);
    end
    return it;
  endfunction

  task automatic report(string msg);
    fail_count++;
    if (fail_count <= 100) $display("ERROR: %s", msg);
  endtask

  task automatic check_field(string name, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
    if (got !== want)
      report($sformatf("result %0d %s: got %0h, expected %0h", result_count, name, got, want));
  endtask

  // Offers one item and holds it until accepted; returns at a falling edge.
  task automatic send_item(req_t it, logic typed, rsp_t typed_rsp);
    rsp_t predicted;
    req <= it;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    predicted = police(it);
    pending_rsp = {pending_rsp, (typed ? typed_rsp : predicted)};
    @(negedge clk);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  task automatic run_random(int count);
    repeat (count) send_item(pick_item(), 1'b0, UNTYPED);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    wait (pending_rsp.size() == 0);
    @(negedge clk);
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] cap, logic [CFG_DATA_W-1:0] rate);
    cfg_valid <= 1'b1;
    cfg_index <= REG_CAPACITY;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cap_reg = cap[CAP_W-1:0];
    @(negedge clk);
    cfg_index <= REG_REFILL;
    cfg_data  <= rate;
    do @(posedge clk); while (!cfg_ready);
    rate_reg = rate[RATE_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Output stall: short random bursts, plus one long hold to back the block up.
  initial begin : stall_gen
    int burst;
    int hold;
    bit held;
    burst = 0;
    hold  = 0;
    held  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) hold--;
      else if (!held && result_count >= 60) begin
        held = 1'b1;
        hold = HOLD_CYCLES;
      end else if (burst > 0) burst--;
      else if (!quiet && $urandom_range(0, 7) == 0) burst = $urandom_range(1, 4);
      rsp_stall <= (hold > 0) || (burst > 0);
    end
  end

  always @(posedge clk) begin : check_result
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      result_count++;
      if (pending_rsp.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", result_count));
      end else begin
        want = pending_rsp.pop_front();
        check_field("granted", CNT_W'(rsp.granted), CNT_W'(want.granted));
        check_field("tokens_left", CNT_W'(rsp.tokens_left), CNT_W'(want.tokens_left));
        check_field("request_total", rsp.request_total, want.request_total);
        check_field("grant_total", rsp.grant_total, want.grant_total);
        check_field("reject_total", rsp.reject_total, want.reject_total);
      end
    end
  end

  initial begin : stimulus
    req_t cur;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (PLAN[k]) begin
      cur.opcode        = PLAN[k].op;
      cur.bucket_index  = PLAN[k].idx;
      cur.now_ms        = PLAN[k].now;
      cur.tokens_wanted = PLAN[k].want;
      send_item(cur, PLAN[k].typed, PLAN[k].rsp);
    end
    run_random(100);
    // Empty buckets that never refill, then the widest settings.
    drain();
    configure(24'd0, 24'd0);
    run_random(60);
    drain();
    configure(24'hFFFFFF, 24'hFFFFFF);
    run_random(100);
    // Buckets left well above the new, lower capacity.
    drain();
    configure(24'd20, 24'd1000);
    run_random(100);
    drain();
    configure(24'd5000, 24'd300);
    run_random(70);
    quiet = 1'b1;
    run_random(70);
    req_valid <= 1'b0;
    wait (pending_rsp.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin : watchdog
    #RUN_LIMIT;
    $display("status: fail");
    $finish;
  end

endmodule
